### hdl/ssrp_pkg.sv
// ============================================================================
// ssrp_pkg
// Shared types and constants for the spindle speed ramp and PWM duty block.
// ============================================================================
package ssrp_pkg;

    typedef logic [15:0] speed_t;
    typedef logic [7:0]  duty_t;
    typedef logic [1:0]  action_t;

    // Item action codes
    localparam action_t ACT_TICK    = 2'd0;
    localparam action_t ACT_SET     = 2'd1;
    localparam action_t ACT_DISABLE = 2'd2;

    // Configuration register indices
    localparam logic [2:0] CFG_MAX_SPEED  = 3'd0;
    localparam logic [2:0] CFG_MIN_SPEED  = 3'd1;
    localparam logic [2:0] CFG_MAX_DUTY   = 3'd2;
    localparam logic [2:0] CFG_RAMP_STEP  = 3'd3;
    localparam logic [2:0] CFG_RAMP_INTVL = 3'd4;
    localparam logic [2:0] CFG_SLOW_START = 3'd5;

    // Register reset values
    localparam speed_t RST_MAX_SPEED  = 16'd24000;
    localparam speed_t RST_MIN_SPEED  = 16'd0;
    localparam duty_t  RST_MAX_DUTY   = 8'd255;
    localparam speed_t RST_RAMP_STEP  = 16'd1000;
    localparam duty_t  RST_RAMP_INTVL = 8'd1;

    // Full-scale duty and ticks per second
    localparam duty_t        DUTY_FULL = 8'd255;
    localparam logic [9:0]   MS_PER_S  = 10'd1000;
    localparam int           WAIT_W    = 18;

endpackage

### hdl/spindle_speed_ramp_pwm.sv
// ============================================================================
// spindle_speed_ramp_pwm
// Spindle speed controller with slow-start ramp and PWM duty computation.
// ============================================================================
// Each item (millisecond tick, set speed or disable) yields one result with
// the duty, the applied speed and an at-target flag. The block takes one item
// at a time: an item passes the step and prep states, and when the applied
// speed is written it may also pass the eight-step restoring divider that
// forms rpm*255/max_speed one quotient bit per cycle. A finished result
// waits in the output register, so the next item can be taken while it is
// still stalled. The user must write configuration through
// cfg_we/cfg_index/cfg_data while idle; the block does not enforce this.
// ============================================================================
module spindle_speed_ramp_pwm
(
    input  logic                clk,
    input  logic                rst_n,
    // configuration write port
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    // item channel
    input  logic                item_valid,
    output logic                item_stall,
    input  ssrp_pkg::action_t   action,
    input  ssrp_pkg::speed_t    rpm_request,
    // result channel
    output logic                result_valid,
    input  logic                result_stall,
    output ssrp_pkg::duty_t     pwm_duty,
    output ssrp_pkg::speed_t    speed_now,
    output logic                at_target
);

    import ssrp_pkg::*;

    // Sequencer state codes
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_STEP = 3'd1;
    localparam logic [2:0] ST_PREP = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_CAP  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    // Configuration registers
    speed_t max_speed_reg, min_speed_reg, ramp_step_reg;
    duty_t  max_duty_reg, ramp_intvl_reg;
    logic   slow_start_reg;

    // Block state
    speed_t            target_reg, target_next;
    speed_t            current_reg, current_next;
    duty_t             duty_reg, duty_next;
    logic [WAIT_W-1:0] wait_reg, wait_next;

    // Sequencer and working registers
    logic [2:0] state_reg, state_next;
    action_t    act_reg, act_next;
    speed_t     rpm_reg, rpm_next;
    logic       write_reg, write_next;
    speed_t     rem_reg, rem_next;
    duty_t      dbits_reg, dbits_next;
    duty_t      quot_reg, quot_next;
    logic [2:0] cnt_reg, cnt_next;

    // Output register
    logic   res_valid_reg, res_valid_next;
    duty_t  res_duty_reg, res_duty_next;
    speed_t res_speed_reg, res_speed_next;
    logic   res_at_reg, res_at_next;

    // Combinational helpers
    logic              item_xfer;
    logic              result_xfer;
    speed_t            rpm_clamped;
    speed_t            ramp_target;
    speed_t            ramp_speed;
    logic              ramp_write;
    speed_t            ramp_diff;
    logic [WAIT_W-1:0] wait_dec;
    logic [WAIT_W-1:0] wait_load;
    logic [23:0]       dividend;
    logic              quot_sat;
    logic [16:0]       trial;
    logic              trial_ge;
    duty_t             sat_duty;

    assign item_xfer   = item_valid && !item_stall;
    assign result_xfer = res_valid_reg && !result_stall;
    assign item_stall  = (state_reg != ST_IDLE);

    assign result_valid = res_valid_reg;
    assign pwm_duty     = res_duty_reg;
    assign speed_now    = res_speed_reg;
    assign at_target    = res_at_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_speed_reg  <= RST_MAX_SPEED;
            min_speed_reg  <= RST_MIN_SPEED;
            max_duty_reg   <= RST_MAX_DUTY;
            ramp_step_reg  <= RST_RAMP_STEP;
            ramp_intvl_reg <= RST_RAMP_INTVL;
            slow_start_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_SPEED:  max_speed_reg  <= cfg_data;
                CFG_MIN_SPEED:  min_speed_reg  <= cfg_data;
                CFG_MAX_DUTY:   max_duty_reg   <= cfg_data[7:0];
                CFG_RAMP_STEP:  ramp_step_reg  <= cfg_data;
                CFG_RAMP_INTVL: ramp_intvl_reg <= cfg_data[7:0];
                CFG_SLOW_START: slow_start_reg <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // Clamp the requested speed to the maximum, then raise a nonzero one to the minimum
    always_comb
    begin
        rpm_clamped = (rpm_request > max_speed_reg) ? max_speed_reg : rpm_request;
        if ((rpm_clamped != '0) && (rpm_clamped < min_speed_reg))
        begin
            rpm_clamped = min_speed_reg;
        end
    end

    // Target seen by the ramp: the new request on set speed, else the held one
    assign ramp_target = (act_reg == ACT_SET) ? rpm_reg : target_reg;

    // One ramp step from the current speed towards the target; a lower target is taken at once
    always_comb
    begin
        ramp_diff  = ramp_target - current_reg;
        ramp_speed = current_reg;
        ramp_write = 1'b0;
        if (ramp_target < current_reg)
        begin
            ramp_speed = ramp_target;
            ramp_write = 1'b1;
        end
        else if (ramp_target > current_reg)
        begin
            ramp_write = 1'b1;
            ramp_speed = (ramp_diff > ramp_step_reg) ? (current_reg + ramp_step_reg)
                                                     : ramp_target;
        end
    end

    assign wait_dec  = (wait_reg != '0) ? (wait_reg - 1'b1) : wait_reg;
    assign wait_load = WAIT_W'(ramp_intvl_reg) * WAIT_W'(MS_PER_S);

    // Duty division: dividend = rpm*255, quotient saturates at full scale
    assign dividend = {current_reg, 8'd0} - {8'd0, current_reg};
    assign quot_sat = (dividend >= {max_speed_reg, 8'd0});
    assign sat_duty = (DUTY_FULL > max_duty_reg) ? max_duty_reg : DUTY_FULL;
    assign trial    = {rem_reg, dbits_reg[7]};
    assign trial_ge = (trial >= {1'b0, max_speed_reg});

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        rpm_next       = rpm_reg;
        write_next     = write_reg;
        target_next    = target_reg;
        current_next   = current_reg;
        duty_next      = duty_reg;
        wait_next      = wait_reg;
        rem_next       = rem_reg;
        dbits_next     = dbits_reg;
        quot_next      = quot_reg;
        cnt_next       = cnt_reg;
        res_valid_next = res_valid_reg;
        res_duty_next  = res_duty_reg;
        res_speed_next = res_speed_reg;
        res_at_next    = res_at_reg;

        // drop the result once taken
        if (result_xfer)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (item_xfer)
                begin
                    act_next   = action;
                    rpm_next   = rpm_clamped;
                    state_next = ST_STEP;
                end
            end

            ST_STEP:
            begin
                write_next = 1'b0;
                case (act_reg)
                    ACT_TICK:
                    begin
                        wait_next = wait_dec;
                        if (slow_start_reg && (target_reg != current_reg)
                            && (wait_dec == '0))
                        begin
                            wait_next    = wait_load;
                            current_next = ramp_speed;
                            write_next   = ramp_write;
                        end
                    end
                    ACT_SET:
                    begin
                        target_next = rpm_reg;
                        if (slow_start_reg)
                        begin
                            current_next = ramp_speed;
                            write_next   = ramp_write;
                        end
                        else
                        begin
                            current_next = rpm_reg;
                            write_next   = 1'b1;
                        end
                    end
                    ACT_DISABLE:
                    begin
                        target_next  = '0;
                        current_next = '0;
                        write_next   = 1'b1;
                    end
                    default: ;
                endcase
                state_next = ST_PREP;
            end

            ST_PREP:
            begin
                if (!write_reg)
                begin
                    state_next = ST_DONE;
                end
                else if (current_reg == '0)
                begin
                    duty_next  = '0;
                    state_next = ST_DONE;
                end
                else if (quot_sat)
                begin
                    duty_next  = sat_duty;
                    state_next = ST_DONE;
                end
                else
                begin
                    // top bits are below the divisor, so eight steps suffice
                    rem_next   = dividend[23:8];
                    dbits_next = dividend[7:0];
                    quot_next  = '0;
                    cnt_next   = '1;
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                rem_next   = trial_ge ? 16'(trial - {1'b0, max_speed_reg}) : trial[15:0];
                dbits_next = {dbits_reg[6:0], 1'b0};
                quot_next  = {quot_reg[6:0], trial_ge};
                cnt_next   = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_CAP;
                end
            end

            ST_CAP:
            begin
                duty_next  = (quot_reg > max_duty_reg) ? max_duty_reg : quot_reg;
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                // hold until the output register is free
                if (!res_valid_reg || !result_stall)
                begin
                    res_valid_next = 1'b1;
                    res_duty_next  = duty_reg;
                    res_speed_next = current_reg;
                    res_at_next    = (target_reg == current_reg);
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and block state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            target_reg    <= '0;
            current_reg   <= '0;
            duty_reg      <= '0;
            wait_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            target_reg    <= target_next;
            current_reg   <= current_next;
            duty_reg      <= duty_next;
            wait_reg      <= wait_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge clk)
    begin
        act_reg       <= act_next;
        rpm_reg       <= rpm_next;
        write_reg     <= write_next;
        rem_reg       <= rem_next;
        dbits_reg     <= dbits_next;
        quot_reg      <= quot_next;
        cnt_reg       <= cnt_next;
        res_duty_reg  <= res_duty_next;
        res_speed_reg <= res_speed_next;
        res_at_reg    <= res_at_next;
    end

endmodule

### tb/spindle_speed_ramp_pwm_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// spindle_speed_ramp_pwm_tb
// Self-checking bench for the spindle speed ramp and PWM duty block.
// ============================================================================
// A short directed run walks through clamping, raising to the minimum speed,
// immediate decreases, a zero ramp step, a minimum above the maximum, a zero
// maximum, slow start switched off with a ramp left unfinished, disable and
// the unused action code. Random phases follow, each under a fresh register
// setting, with a long final phase at a one-second interval so that the tick
// countdown runs out. Every transfer on the item channel is fed to an
// in-bench copy of the controller, and each result transfer is compared field
// by field with the oldest predicted status. Both channels idle at random,
// and once the result side holds off long enough for the block to back up.
// ============================================================================
module spindle_speed_ramp_pwm_tb;

    import ssrp_pkg::*;

    // Action code with no function: the block only reports its status
    localparam action_t ACT_UNUSED       = 2'd3;
    localparam int      SETTLE_CYCLES    = 16;
    localparam int      MISMATCH_REPORTS = 10;
    localparam int      HOLD_OFF_CYCLES  = 300;

    typedef struct packed {
        duty_t  duty;
        speed_t speed;
        logic   at_target;
    } spindle_status_t;

    // ------------------------------------------------------------------------
    // Controller copy and store of predicted status
    // ------------------------------------------------------------------------
    class speed_ramp_checker;
        bit [15:0]       max_speed;
        bit [15:0]       min_speed;
        bit [7:0]        max_duty;
        bit [15:0]       ramp_step;
        bit [7:0]        ramp_interval_s;
        bit              slow_start_on;
        bit [15:0]       target_speed;
        bit [15:0]       current_speed;
        bit [7:0]        current_duty;
        bit [WAIT_W-1:0] wait_ticks;
        spindle_status_t predicted_status[$];
        int              mismatches;

        function new();
            max_speed       = RST_MAX_SPEED;
            min_speed       = RST_MIN_SPEED;
            max_duty        = RST_MAX_DUTY;
            ramp_step       = RST_RAMP_STEP;
            ramp_interval_s = RST_RAMP_INTVL;
            slow_start_on   = 1'b1;
            target_speed    = '0;
            current_speed   = '0;
            current_duty    = '0;
            wait_ticks      = '0;
            mismatches      = 0;
        endfunction

        function void write_register(logic [2:0] index, logic [15:0] value);
            case (index)
                CFG_MAX_SPEED:  max_speed       = value;
                CFG_MIN_SPEED:  min_speed       = value;
                CFG_MAX_DUTY:   max_duty        = value[7:0];
                CFG_RAMP_STEP:  ramp_step       = value;
                CFG_RAMP_INTVL: ramp_interval_s = value[7:0];
                CFG_SLOW_START: slow_start_on   = value[0];
                default: ;
            endcase
        endfunction

        // Scale to full range, saturate at 255, then apply the duty cap
        function bit [7:0] duty_for(bit [15:0] rpm);
            bit [31:0] quotient;
            if (max_speed == 0)
                quotient = (rpm == 0) ? 32'd0 : 32'(DUTY_FULL);
            else
                quotient = (32'(rpm) * 32'(DUTY_FULL)) / 32'(max_speed);
            if (quotient > 32'(DUTY_FULL))
                quotient = 32'(DUTY_FULL);
            if (quotient > 32'(max_duty))
                quotient = 32'(max_duty);
            return quotient[7:0];
        endfunction

        function void apply_speed(bit [15:0] rpm);
            current_speed = rpm;
            current_duty  = duty_for(rpm);
        endfunction

        // Drop straight to a lower target, climb by at most one ramp step
        function void ramp_toward_target();
            if (target_speed < current_speed)
                apply_speed(target_speed);
            else if (target_speed > current_speed)
            begin
                if (target_speed - current_speed > ramp_step)
                    apply_speed(current_speed + ramp_step);
                else
                    apply_speed(target_speed);
            end
        endfunction

        function void note_item(action_t act, speed_t rpm_in);
            bit [15:0]       rpm;
            bit [31:0]       interval_ticks;
            spindle_status_t status;
            rpm = rpm_in;
            case (act)
                ACT_TICK:
                begin
                    if (wait_ticks != 0)
                        wait_ticks--;
                    if (slow_start_on && target_speed != current_speed && wait_ticks == 0)
                    begin
                        interval_ticks = 32'(ramp_interval_s) * 32'(MS_PER_S);
                        wait_ticks     = interval_ticks[WAIT_W-1:0];
                        ramp_toward_target();
                    end
                end
                ACT_SET:
                begin
                    if (rpm > max_speed)
                        rpm = max_speed;
                    if (rpm != 0 && rpm < min_speed)
                        rpm = min_speed;
                    target_speed = rpm;
                    if (slow_start_on)
                        ramp_toward_target();
                    else
                        apply_speed(rpm);
                end
                ACT_DISABLE:
                begin
                    target_speed  = '0;
                    current_speed = '0;
                    current_duty  = '0;
                end
                default: ;
            endcase
            status.duty      = current_duty;
            status.speed     = current_speed;
            status.at_target = (target_speed == current_speed);
            predicted_status.push_back(status);
        endfunction

        function void flag_mismatch(string what);
            mismatches++;
            if (mismatches <= MISMATCH_REPORTS)
                $display("[%0t] MISMATCH: %s", $time, what);
        endfunction

        function void check_result(duty_t duty, speed_t speed, logic at_tgt);
            spindle_status_t want;
            if (predicted_status.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected result duty=%0d speed=%0d at_target=%b",
                                        duty, speed, at_tgt));
                return;
            end
            want = predicted_status.pop_front();
            if (duty !== want.duty || speed !== want.speed || at_tgt !== want.at_target)
                flag_mismatch($sformatf(
                    "expected duty=%0d speed=%0d at_target=%b, got duty=%0d speed=%0d at_target=%b",
                    want.duty, want.speed, want.at_target, duty, speed, at_tgt));
        endfunction

        function int pending();
            return predicted_status.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and block instance
    // ------------------------------------------------------------------------
    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [2:0] cfg_index;
    logic [15:0] cfg_data;
    logic       item_valid;
    logic       item_stall;
    action_t    action;
    speed_t     rpm_request;
    logic       result_valid;
    logic       result_stall;
    duty_t      pwm_duty;
    speed_t     speed_now;
    logic       at_target;

    speed_ramp_checker checker_h;
    bit                hold_requested = 1'b0;
    int                steady_left    = 0;

    spindle_speed_ramp_pwm i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .action       (action),
        .rpm_request  (rpm_request),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .pwm_duty     (pwm_duty),
        .speed_now    (speed_now),
        .at_target    (at_target)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard limit on the run
    initial
    begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Transfer monitor: check results first, then predict from new items
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result_valid === 1'b1 && result_stall === 1'b0)
            checker_h.check_result(pwm_duty, speed_now, at_target);
        if (rst_n === 1'b1 && item_valid === 1'b1 && item_stall === 1'b0)
            checker_h.note_item(action, rpm_request);
    end

    // ------------------------------------------------------------------------
    // Result side: random stall bursts, plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin : result_side
        int   burst_left;
        int   pick;
        logic stalling;
        burst_left = 0;
        stalling   = 1'b0;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requested)
            begin
                hold_requested = 1'b0;
                result_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                burst_left = 0;
            end
            else
            begin
                if (burst_left == 0)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 45)
                    begin
                        stalling   = 1'b0;
                        burst_left = $urandom_range(1, 6);
                    end
                    else if (pick < 80)
                    begin
                        stalling   = 1'b1;
                        burst_left = $urandom_range(1, 3);
                    end
                    else if (pick < 95)
                    begin
                        stalling   = 1'b0;
                        burst_left = $urandom_range(20, 80);
                    end
                    else
                    begin
                        stalling   = 1'b1;
                        burst_left = $urandom_range(10, 40);
                    end
                end
                result_stall <= stalling;
                burst_left--;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Item side helpers
    // ------------------------------------------------------------------------
    // Mostly back to back, some short gaps, a few long ones, and steady runs
    function automatic int pick_gap();
        int pick;
        if (steady_left > 0)
        begin
            steady_left--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 5)
        begin
            steady_left = $urandom_range(20, 60);
            return 0;
        end
        if (pick < 60)
            return 0;
        if (pick < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    // Leaves valid high on the accepting edge when no gap follows
    task automatic send_item(action_t act, speed_t rpm);
        int gap;
        item_valid  <= 1'b1;
        action      <= act;
        rpm_request <= rpm;
        @(posedge clk);
        while (item_stall !== 1'b0)
            @(posedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (checker_h.pending() != 0)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(logic [2:0] index, logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        checker_h.write_register(index, value);
    endtask

    task automatic program_registers(speed_t max_s, speed_t min_s, duty_t duty_cap,
                                     speed_t step, duty_t intvl, logic slow);
        write_cfg(CFG_MAX_SPEED, max_s);
        write_cfg(CFG_MIN_SPEED, min_s);
        write_cfg(CFG_MAX_DUTY, {8'd0, duty_cap});
        write_cfg(CFG_RAMP_STEP, step);
        write_cfg(CFG_RAMP_INTVL, {8'd0, intvl});
        write_cfg(CFG_SLOW_START, {15'd0, slow});
        cfg_we <= 1'b0;
    endtask

    // Bias the request towards the clamp and minimum boundaries
    function automatic speed_t choose_rpm();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 16'hFFFF;
            2, 3, 4: return speed_t'($urandom_range(0, checker_h.max_speed));
            5:       return speed_t'(checker_h.min_speed + $urandom_range(0, 3));
            6:       return speed_t'(checker_h.max_speed + $urandom_range(0, 3));
            default: return speed_t'($urandom_range(0, 65535));
        endcase
    endfunction

    // Random setting with the ramp interval held at zero
    task automatic random_config();
        speed_t max_s;
        speed_t min_s;
        duty_t  duty_cap;
        speed_t step;
        case ($urandom_range(0, 19))
            0:                         max_s = '0;
            1:                         max_s = 16'hFFFF;
            2, 3, 4, 5, 6, 7, 8, 9:    max_s = speed_t'($urandom_range(1, 2000));
            default:                   max_s = speed_t'($urandom_range(1, 65535));
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2: min_s = '0;
            3:       min_s = 16'hFFFF;
            4:       min_s = speed_t'($urandom_range(0, 65535));
            default: min_s = speed_t'($urandom_range(0, max_s));
        endcase
        case ($urandom_range(0, 9))
            0, 1:    duty_cap = '0;
            2, 3, 4: duty_cap = duty_t'($urandom_range(0, 255));
            default: duty_cap = DUTY_FULL;
        endcase
        case ($urandom_range(0, 9))
            0:       step = '0;
            1:       step = 16'hFFFF;
            2, 3, 4, 5, 6, 7: step = speed_t'($urandom_range(1, 200));
            default: step = speed_t'($urandom_range(1, 65535));
        endcase
        program_registers(max_s, min_s, duty_cap, step, 8'd0, ($urandom_range(0, 4) != 0));
    endtask

    task automatic run_random_phase(int count, int tick_pct);
        action_t act;
        int      pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < tick_pct)
                act = ACT_TICK;
            else
            begin
                pick = $urandom_range(0, 19);
                if (pick < 15)
                    act = ACT_SET;
                else if (pick < 18)
                    act = ACT_DISABLE;
                else
                    act = ACT_UNUSED;
            end
            send_item(act, choose_rpm());
            // Occasionally stop offering until every result is back
            if ($urandom_range(0, 99) == 0)
            begin
                item_valid <= 1'b0;
                wait_drained();
            end
        end
        item_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        checker_h = new();
        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= CFG_MAX_SPEED;
        cfg_data    <= '0;
        item_valid  <= 1'b0;
        action      <= ACT_TICK;
        rpm_request <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset setting: clamp to maximum, immediate decrease, partial climb
        send_item(ACT_TICK, 16'h0000);
        send_item(ACT_SET, 16'hFFFF);
        send_item(ACT_SET, 16'h0000);
        send_item(ACT_SET, 16'd1500);
        send_item(ACT_DISABLE, 16'hFFFF);
        send_item(ACT_UNUSED, 16'hFFFF);
        send_item(ACT_SET, 16'd500);
        send_item(ACT_TICK, 16'h5A5A);
        item_valid <= 1'b0;
        wait_idle();

        // Zero ramp step: raise to minimum, then no progress on ticks
        program_registers(16'd300, 16'd100, 8'd100, 16'd0, 8'd0, 1'b1);
        send_item(ACT_SET, 16'd0);
        send_item(ACT_SET, 16'd50);
        send_item(ACT_TICK, 16'd0);
        send_item(ACT_TICK, 16'hA5A5);
        item_valid <= 1'b0;
        wait_idle();

        // Slow start off with a ramp left open; minimum above maximum
        program_registers(16'd1, 16'hFFFF, DUTY_FULL, 16'hFFFF, 8'd255, 1'b0);
        send_item(ACT_TICK, 16'd0);
        send_item(ACT_SET, 16'd5);
        send_item(ACT_SET, 16'd0);
        send_item(ACT_SET, 16'hFFFF);
        item_valid <= 1'b0;
        wait_idle();

        // Open a slow climb, then take a step under a zero maximum
        program_registers(16'hFFFF, 16'd0, DUTY_FULL, 16'd1, 8'd0, 1'b1);
        send_item(ACT_SET, 16'hFFFF);
        send_item(ACT_TICK, 16'd0);
        item_valid <= 1'b0;
        wait_idle();
        program_registers(16'd0, 16'd0, 8'd200, 16'd1, 8'd0, 1'b1);
        send_item(ACT_TICK, 16'd0);
        send_item(ACT_SET, 16'd9);
        item_valid <= 1'b0;
        wait_idle();

        // Random phases at a zero interval; one of them backs up the block
        for (int phase = 0; phase < 6; phase++)
        begin
            random_config();
            if (phase == 2)
                hold_requested = 1'b1;
            run_random_phase(100, 70);
            wait_idle();
        end

        // One-second interval: long countdowns between ramp steps
        program_registers(16'd24000, 16'd0, DUTY_FULL, 16'd2000, 8'd1, 1'b1);
        run_random_phase(1050, 97);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (checker_h.mismatches == 0 && checker_h.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
